FILE: rtl/hubs_pkg.sv
// Shared widths, limits and word types of the harmonic upper-bound score block.
`default_nettype none
package hubs_pkg;

  localparam int COORD_W   = 24;               // Q16.8 coordinate and bound
  localparam int MAG_W     = COORD_W + 1;      // magnitude of a coordinate difference
  localparam int D2_W      = 2 * MAG_W;        // squared distance, Q.16
  localparam int ROOT_W    = MAG_W;            // distance, Q.8
  localparam int SIGMA_W   = 16;               // sigma, Q8.8
  localparam int DEN_W     = 2 * SIGMA_W + 1;  // 2*sigma^2, Q.16
  localparam int TERM_W    = 40;               // pair term, Q24.16
  localparam int TERM_FRAC = 16;
  localparam int SUM_W     = 48;               // running score, Q32.16

  localparam logic [SIGMA_W-1:0] SIGMA_RESET = SIGMA_W'(256);
  localparam logic [TERM_W-1:0]  TERM_MAX    = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX     = '1;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic [COORD_W-1:0]        bound_distance;
    logic                      last_pair;
  } pair_t;

  typedef struct packed {
    logic [TERM_W-1:0] pair_term;
    logic [SUM_W-1:0]  running_score;
    logic              score_done;
  } score_t;

endpackage
`default_nettype wire

FILE: rtl/hubs_pair_if.sv
// Valid/ready channel that carries one residue pair word.
`default_nettype none
interface hubs_pair_if;
  logic            valid;
  logic            ready;
  hubs_pkg::pair_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/hubs_score_if.sv
// Valid/ready channel that carries one score result word.
`default_nettype none
interface hubs_score_if;
  logic             valid;
  logic             ready;
  hubs_pkg::score_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/hubs_sq.sv
// Shared squaring unit with a registered product.
`default_nettype none
module hubs_sq (
  input  logic                      clk_i,
  input  logic [hubs_pkg::MAG_W-1:0] op_i,
  output logic [hubs_pkg::D2_W-1:0]  sq_o
);
  import hubs_pkg::*;

  logic [D2_W-1:0] ext;
  logic [D2_W-1:0] sq_q;

  assign ext = D2_W'(op_i);

  always_ff @(posedge clk_i) begin
    sq_q <= ext * ext;
  end

  assign sq_o = sq_q;
endmodule
`default_nettype wire

FILE: rtl/hubs_sqrt.sv
// Iterative integer square root, one root bit per cycle.
`default_nettype none
module hubs_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hubs_pkg::D2_W-1:0]   radicand_i,
  output logic                        done_o,
  output logic [hubs_pkg::ROOT_W-1:0] root_o
);
  import hubs_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

  logic [D2_W-1:0]   rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[D2_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[D2_W-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

FILE: rtl/hubs_div.sv
// Iterative restoring divider for excess^2 * 2^16 / (2*sigma^2), saturating.
`default_nettype none
module hubs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hubs_pkg::D2_W-1:0]   num_i,
  input  logic [hubs_pkg::DEN_W-1:0]  den_i,
  output logic                        done_o,
  output logic [hubs_pkg::TERM_W-1:0] quo_o
);
  import hubs_pkg::*;

  localparam int HI_LSB = TERM_W - TERM_FRAC;
  localparam int CNT_W  = $clog2(TERM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TERM_W - 1);

  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [TERM_W-1:0] lo_q;
  logic [TERM_W-1:0] q_q;
  logic              sat_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [DEN_W-1:0]  num_hi;
  logic [DEN_W:0]    t;
  logic [DEN_W:0]    t_sub;
  logic              ge;

  // quotient needs more than TERM_W bits exactly when num >> 24 >= den (den zero included)
  assign num_hi = DEN_W'(num_i[D2_W-1:HI_LSB]);
  assign t      = {rem_q, lo_q[TERM_W-1]};
  assign t_sub  = t - {1'b0, den_q};
  assign ge     = t >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_hi;
      den_q <= den_i;
      lo_q  <= {num_i[HI_LSB-1:0], TERM_FRAC'(0)};
      q_q   <= '0;
      sat_q <= num_hi >= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? t_sub[DEN_W-1:0] : t[DEN_W-1:0];
      lo_q  <= {lo_q[TERM_W-2:0], 1'b0};
      q_q   <= {q_q[TERM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = sat_q ? TERM_MAX : q_q;
endmodule
`default_nettype wire

FILE: rtl/harmonic_upper_bound_score.sv
// Harmonic upper-bound distance score: sequencer around a shared squarer, root and divider.
// Sequence: the result word is registered after the 25-step square root and, when the distance
//   exceeds the bound, the 40-step divider.
// Flow: one pair at a time; while the output is stalled the result waits in ST_OUT, and the
//   next word is accepted in the cycle after the result is registered.
// Reset: sigma returns to 1.0, the running score to zero, the output register empties.
`default_nettype none
module harmonic_upper_bound_score (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hubs_pkg::SIGMA_W-1:0] cfg_wdata_i,
  hubs_pair_if.sink                    pair_i,
  hubs_score_if.source                 score_o
);
  import hubs_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_SQ      = 8'b0000_0010,
    ST_RT_GO   = 8'b0000_0100,
    ST_RT_WAIT = 8'b0000_1000,
    ST_EX      = 8'b0001_0000,
    ST_DV_GO   = 8'b0010_0000,
    ST_DV_WAIT = 8'b0100_0000,
    ST_OUT     = 8'b1000_0000
  } state_e;

  function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
    logic [MAG_W-1:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[MAG_W-1] ? (MAG_W'(0) - d) : d;
  endfunction

  state_e            state_q, state_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [SIGMA_W-1:0] sigma_q;
  logic [SUM_W-1:0]  score_sum_q;
  logic              out_valid_q;
  score_t            out_data_q;

  logic [MAG_W-1:0]   mag_q [3];
  logic [COORD_W-1:0] bound_q;
  logic               last_q;
  logic [D2_W-1:0]    d2_q;
  logic [ROOT_W-1:0]  dist_q;
  logic               above_q;
  logic [D2_W-1:0]    ex2_q;
  logic [DEN_W-1:0]   den_q;

  logic               in_accept;
  logic               out_load;
  logic               rt_start, rt_done;
  logic               dv_start, dv_done;
  logic [ROOT_W-1:0]  rt_root;
  logic [TERM_W-1:0]  dv_quo;
  logic [MAG_W-1:0]   sq_op;
  logic [D2_W-1:0]    sq_prod;
  logic [ROOT_W-1:0]  excess;
  logic               dist_above;
  logic [TERM_W-1:0]  term;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_sat;

  assign in_accept  = pair_i.valid && pair_i.ready;
  assign pair_i.ready = (state_q == ST_IDLE);

  assign dist_above = dist_q > ROOT_W'(bound_q);
  assign excess     = dist_q - ROOT_W'(bound_q);

  // operand of the shared squarer: three coordinate differences, then excess and sigma
  always_comb begin
    sq_op = '0;
    case (state_q)
      ST_SQ: begin
        case (cnt_q)
          2'd0:    sq_op = mag_q[0];
          2'd1:    sq_op = mag_q[1];
          2'd2:    sq_op = mag_q[2];
          default: sq_op = '0;
        endcase
      end
      ST_EX: begin
        sq_op = (cnt_q == 2'd0) ? excess : MAG_W'(sigma_q);
      end
      default: sq_op = '0;
    endcase
  end

  hubs_sq u_sq (
    .clk_i (clk_i),
    .op_i  (sq_op),
    .sq_o  (sq_prod)
  );

  hubs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rt_start),
    .radicand_i (d2_q),
    .done_o     (rt_done),
    .root_o     (rt_root)
  );

  hubs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (ex2_q),
    .den_i   (den_q),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rt_start = 1'b0;
    dv_start = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pair_i.valid) begin
          state_d = ST_SQ;
          cnt_d   = '0;
        end
      end
      ST_SQ: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = ST_RT_GO;
        end
      end
      ST_RT_GO: begin
        rt_start = 1'b1;
        state_d  = ST_RT_WAIT;
      end
      ST_RT_WAIT: begin
        if (rt_done) begin
          state_d = ST_EX;
          cnt_d   = '0;
        end
      end
      ST_EX: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd0 && !dist_above) begin
          state_d = ST_OUT;
        end else if (cnt_q == 2'd2) begin
          state_d = ST_DV_GO;
        end
      end
      ST_DV_GO: begin
        dv_start = 1'b1;
        state_d  = ST_DV_WAIT;
      end
      ST_DV_WAIT: begin
        if (dv_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || score_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mag_q[0] <= abs_diff(pair_i.data.first_x, pair_i.data.second_x);
      mag_q[1] <= abs_diff(pair_i.data.first_y, pair_i.data.second_y);
      mag_q[2] <= abs_diff(pair_i.data.first_z, pair_i.data.second_z);
      bound_q  <= pair_i.data.bound_distance;
      last_q   <= pair_i.data.last_pair;
    end
    if (state_q == ST_SQ) begin
      if (cnt_q == 2'd1) begin
        d2_q <= sq_prod;
      end else if (cnt_q != 2'd0) begin
        d2_q <= d2_q + sq_prod;
      end
    end
    if (state_q == ST_RT_WAIT && rt_done) begin
      dist_q <= rt_root;
    end
    if (state_q == ST_EX) begin
      if (cnt_q == 2'd0) begin
        above_q <= dist_above;
      end else if (cnt_q == 2'd1) begin
        ex2_q <= sq_prod;
      end else begin
        den_q <= {sq_prod[DEN_W-2:0], 1'b0};
      end
    end
  end

  assign term    = above_q ? dv_quo : '0;
  assign sum_ext = {1'b0, score_sum_q} + (SUM_W + 1)'(term);
  assign sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.pair_term     <= term;
      out_data_q.running_score <= sum_sat;
      out_data_q.score_done    <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      sigma_q     <= SIGMA_RESET;
      score_sum_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        sigma_q <= cfg_wdata_i;
      end
      if (out_load) begin
        score_sum_q <= last_q ? '0 : sum_sat;
        out_valid_q <= 1'b1;
      end else if (score_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign score_o.valid = out_valid_q;
  assign score_o.data  = out_data_q;

  // a word is taken only from idle, so the port closes right after
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !pair_i.ready)
    else $error("pair word accepted while busy");

  a_sum_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |=> (score_sum_q == '0))
    else $error("running score not cleared after last pair");

  a_term_in_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    score_o.valid |-> (score_o.data.pair_term <= TERM_W'(score_o.data.running_score)
                       || score_o.data.running_score[SUM_W-1:TERM_W] != '0))
    else $error("pair term exceeds running score");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_done |-> (state_q == ST_DV_WAIT))
    else $error("divider finished outside its wait state");

endmodule
`default_nettype wire

FILE: tb/score_checker.sv
// Checker for the harmonic upper-bound score block: watches both channels, predicts, compares.
module score_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hubs_pkg::SIGMA_W-1:0] cfg_wdata_i,
  hubs_pair_if                         pair_mon,
  hubs_score_if                        score_mon,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hubs_pkg::*;

  logic [SIGMA_W-1:0] sigma_q;
  logic [SUM_W-1:0]   score_total;
  score_t             expected_scores[$];

  score_t             want;
  logic [TERM_W-1:0]  term;
  logic [SUM_W:0]     total;

  function automatic logic [63:0] axis_square(logic signed [COORD_W-1:0] a,
                                              logic signed [COORD_W-1:0] b);
    longint diff;
    diff = longint'(a) - longint'(b);
    if (diff < 0) diff = -diff;
    return 64'(diff * diff);
  endfunction

  // Bit-serial floor square root; the squared distance stays below 2^50.
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [TERM_W-1:0] pair_penalty(pair_t p, logic [SIGMA_W-1:0] sigma);
    logic [63:0] root_len;
    logic [63:0] excess;
    logic [63:0] excess_sq;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    root_len = floor_root(axis_square(p.first_x, p.second_x) +
                          axis_square(p.first_y, p.second_y) +
                          axis_square(p.first_z, p.second_z));
    if (root_len <= 64'(p.bound_distance)) return '0;
    excess    = root_len - 64'(p.bound_distance);
    excess_sq = excess * excess;
    den       = 64'd2 * 64'(sigma) * 64'(sigma);
    if (den == 0) return TERM_MAX;   // divide by zero reads as all ones
    quo = excess_sq / den;
    rem = excess_sq % den;
    if (quo >= (64'd1 << (TERM_W - TERM_FRAC))) return TERM_MAX;
    return TERM_W'((quo << TERM_FRAC) + ((rem << TERM_FRAC) / den));
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] exp_val);
    $display("%0t score mismatch on %s: got %0h, want %0h", $realtime, field, got, exp_val);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q      = SIGMA_RESET;
      score_total  = '0;
      fail_count_o = 0;
      expected_scores.delete();
    end else begin
      if (cfg_we_i) sigma_q = cfg_wdata_i;

      if (pair_mon.valid && pair_mon.ready) begin
        term  = pair_penalty(pair_mon.data, sigma_q);
        total = {1'b0, score_total} + (SUM_W + 1)'(term);
        if (total > {1'b0, SUM_MAX}) total = {1'b0, SUM_MAX};
        want.pair_term     = term;
        want.running_score = total[SUM_W-1:0];
        want.score_done    = pair_mon.data.last_pair;
        expected_scores.insert(expected_scores.size(), want);
        score_total = pair_mon.data.last_pair ? '0 : total[SUM_W-1:0];
      end

      if (score_mon.valid && score_mon.ready) begin
        if (expected_scores.size() == 0) begin
          report("unexpected word", 64'(score_mon.data.running_score), '0);
        end else begin
          want = expected_scores.pop_front();
          if (score_mon.data.pair_term !== want.pair_term)
            report("pair_term", 64'(score_mon.data.pair_term), 64'(want.pair_term));
          if (score_mon.data.running_score !== want.running_score)
            report("running_score", 64'(score_mon.data.running_score),
                   64'(want.running_score));
          if (score_mon.data.score_done !== want.score_done)
            report("score_done", 64'(score_mon.data.score_done), 64'(want.score_done));
        end
      end
    end
    pending_o = expected_scores.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the harmonic upper-bound score testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hubs_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [SIGMA_W-1:0] cfg_wdata;
  logic               hold_req;
  logic               tx_quiet;
  logic               rx_quiet;
  int                 fail_count;
  int                 pending;

  hubs_pair_if  pair_if();
  hubs_score_if score_if();

  harmonic_upper_bound_score dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pair_i      (pair_if),
    .score_o     (score_if)
  );

  score_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .pair_mon     (pair_if),
    .score_mon    (score_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic signed [COORD_W-1:0] rand_coord(int lo_shift, int hi_shift);
    logic signed [COORD_W-1:0] raw;
    raw = COORD_W'($urandom);
    return raw >>> $urandom_range(lo_shift, hi_shift);
  endfunction

  function automatic pair_t make_pair(int fx, int fy, int fz, int sx, int sy, int sz,
                                      int bound, bit last);
    pair_t p;
    p.first_x        = COORD_W'(fx);
    p.first_y        = COORD_W'(fy);
    p.first_z        = COORD_W'(fz);
    p.second_x       = COORD_W'(sx);
    p.second_y       = COORD_W'(sy);
    p.second_z       = COORD_W'(sz);
    p.bound_distance = COORD_W'(bound);
    p.last_pair      = last;
    return p;
  endfunction

  // Near pairs keep the distance small, so it can land close to small bounds.
  function automatic pair_t random_pair(int lo_shift, int hi_shift, bit near_ok, bit last);
    pair_t p;
    p.first_x = rand_coord(lo_shift, hi_shift);
    p.first_y = rand_coord(lo_shift, hi_shift);
    p.first_z = rand_coord(lo_shift, hi_shift);
    if (near_ok && $urandom_range(0, 2) == 0) begin
      p.second_x = p.first_x + rand_coord(10, 23);
      p.second_y = p.first_y + rand_coord(10, 23);
      p.second_z = p.first_z + rand_coord(10, 23);
    end else begin
      p.second_x = rand_coord(lo_shift, hi_shift);
      p.second_y = rand_coord(lo_shift, hi_shift);
      p.second_z = rand_coord(lo_shift, hi_shift);
    end
    p.bound_distance = COORD_W'($urandom) >> $urandom_range(near_ok ? 0 : 8, 24);
    p.last_pair      = last;
    return p;
  endfunction

  task automatic send_pair(pair_t p);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      pair_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pair_if.valid <= 1'b1;
    pair_if.data  <= p;
    do @(posedge clk_i); while (!(pair_if.valid && pair_if.ready));
  endtask

  // Called on the edge of the last accept; returns on a rising edge with the block idle.
  task automatic drain_scores();
    pair_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_sigma(logic [SIGMA_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random stalls, quiet stretches, and one long hold on request.
  initial begin
    int gap;
    int served;
    bit held;
    served         = 0;
    held           = 1'b0;
    rx_quiet       = 1'b0;
    score_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        gap = rx_quiet ? 0 : $urandom_range(0, 8);
      end
      if (gap > 0) begin
        score_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      score_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(score_if.valid && score_if.ready));
      served++;
      if (served % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    logic [SIGMA_W-1:0] sigma_plan[5];
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    pair_if.valid = 1'b0;
    pair_if.data  = '0;
    hold_req      = 1'b0;
    tx_quiet      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, sigma at its reset value of 1.0.
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 0, 0));
    send_pair(make_pair(8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
                        16777215, 0));
    send_pair(make_pair(0, 0, 0, 768, 1024, 0, 1280, 0));   // distance equals bound
    send_pair(make_pair(0, 0, 0, 768, 1024, 0, 1279, 0));   // term rounds down to zero
    send_pair(make_pair(0, 0, 0, 768, 1024, 0, 1024, 0));
    send_pair(make_pair(0, 0, 0, 768, 1024, 0, 0, 1));
    send_pair(make_pair(100, -200, 300, -100, 200, -300, 16777215, 1));
    send_pair(make_pair(-1, -1, -1, 0, 0, 0, 0, 0));
    send_pair(make_pair(-256, 512, -768, 256, -512, 768, 255, 1));
    drain_scores();

    // Zero sigma: saturated term above the bound, zero below it.
    write_sigma('0);
    send_pair(make_pair(5, 5, 5, 5, 5, 5, 5, 0));
    send_pair(make_pair(0, 0, 0, 0, 0, 1, 0, 1));
    drain_scores();

    write_sigma('1);
    send_pair(make_pair(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 0, 0));
    send_pair(make_pair(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 0, 1));
    drain_scores();

    // Random phases across several sigma settings.
    sigma_plan = '{SIGMA_W'(0), '1, SIGMA_W'(1), SIGMA_W'($urandom_range(2, 65534)),
                   SIGMA_RESET};
    foreach (sigma_plan[ph]) begin
      write_sigma(sigma_plan[ph]);
      tx_quiet = ($urandom_range(0, 3) == 0);
      if (ph == 0) hold_req = 1'b1;   // stall the result side long enough to back up input
      for (int i = 0; i < 24; i++)
        send_pair(random_pair(0, 23, 1'b1, $urandom_range(0, 7) == 0));
      drain_scores();
    end

    // One long evaluation of mostly saturated terms drives the total into saturation.
    write_sigma(SIGMA_W'(1));
    tx_quiet = 1'b0;
    for (int i = 0; i < 280; i++)
      send_pair(random_pair(0, 2, 1'b0, i == 279));
    drain_scores();

    repeat (100) @(posedge clk_i);
    if (fail_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/hubs_pkg.sv
rtl/hubs_pair_if.sv
rtl/hubs_score_if.sv
rtl/hubs_sq.sv
rtl/hubs_sqrt.sv
rtl/hubs_div.sv
rtl/harmonic_upper_bound_score.sv
tb/score_checker.sv
tb/testbench.sv
